// ===== rtl/dwbs_pkg.sv =====
// Shared types, sizes and codes for the deque with bag search.
// No dependencies; every other file of the block but dwbs_ram imports this package.
package dwbs_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam cnt_t  CNT_ZERO  = '0;
  localparam cnt_t  CNT_ONE   = cnt_t'(1);
  localparam cnt_t  CNT_FULL  = cnt_t'(DEPTH);
  localparam addr_t ADDR_LAST = addr_t'(DEPTH - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_CONTAINS   = 3'd4,
    FUNC_REMOVE     = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Ring position of the k-th entry from the front (k below DEPTH)
  function automatic addr_t slot_of(addr_t head, cnt_t k);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, k[ADDR_W-1:0]};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Step the ring position one place back, wrapping at zero
  function automatic addr_t prev_slot(addr_t head);
    return (head == '0) ? ADDR_LAST : head - addr_t'(1);
  endfunction

  // Step the ring position one place forward, wrapping at the end
  function automatic addr_t next_slot(addr_t head);
    return (head == ADDR_LAST) ? '0 : head + addr_t'(1);
  endfunction

endpackage

// ===== rtl/dwbs_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on dwbs_pkg for field widths.
interface dwbs_req_if import dwbs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output func, output data_value, input ready);
  modport sink   (input valid, input func, input data_value, output ready);
endinterface

interface dwbs_rsp_if import dwbs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [COUNT_W-1:0]       entry_count;
  logic                     is_empty;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output found, output front_value, output back_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input found, input front_value, input back_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface

// ===== rtl/dwbs_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; sized by its parameters.
module dwbs_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(WORDS)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(WORDS)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/deque_with_bag_search.sv =====
// Bounded double-ended queue of signed 32-bit values, also searchable as a bag.
// Depends on dwbs_pkg, dwbs_if (request/result channels) and dwbs_ram.
//
// One request at a time, one result per request. Entries live in a DEPTH-word
// ring RAM with a single, registered read port; front and back values are
// cached in registers. Pop front and pop back do one RAM read to refresh the
// new end, or none when the queue empties or was empty. Contains reads one
// entry per cycle from the front and stops early on a match. Remove then moves
// each entry behind the match one place toward the front to close the gap
// (read and write-back overlap) and, unless the queue empties, reads the RAM
// to refresh front and back. A new request is taken only when the previous
// one is finished; a result waiting in the output register does not block
// acceptance, only completion of the next request.
module deque_with_bag_search import dwbs_pkg::*; (
  input logic        clk,
  input logic        rst,
  dwbs_req_if.sink   req,
  dwbs_rsp_if.source rsp
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_SHIFT    = 8'b0000_0100,
    S_FRONT_RD = 8'b0000_1000,
    S_FRONT_WR = 8'b0001_0000,
    S_BACK_RD  = 8'b0010_0000,
    S_BACK_WR  = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t  state;
  addr_t   head;
  cnt_t    count;
  word_t   front;
  word_t   back;
  word_t   val;
  func_t   op;
  logic    op_found;
  status_t op_status;
  cnt_t    scan_k;
  cnt_t    rd_idx;
  logic    rd_vld;
  logic    need_back;
  logic    rsp_valid;

  logic    wr_en;
  addr_t   wr_addr;
  word_t   wr_data;
  logic    rd_en;
  addr_t   rd_addr;
  word_t   rd_data;
  logic    match;

  dwbs_ram #(
    .WIDTH (DATA_W),
    .WORDS (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign match     = rd_vld && (rd_data == val);

  // Drive the RAM ports for the current step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = req.data_value;
    rd_en   = 1'b0;
    rd_addr = slot_of(head, scan_k);
    case (state)
      S_IDLE: begin
        if (req.valid && count < CNT_FULL) begin
          if (func_t'(req.func) == FUNC_PUSH_FRONT) begin
            wr_en   = 1'b1;
            wr_addr = prev_slot(head);
          end else if (func_t'(req.func) == FUNC_PUSH_BACK) begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head, count);
          end
        end
      end
      S_SCAN: begin
        if (!match && scan_k < count) begin
          rd_en = 1'b1;
        end
      end
      S_SHIFT: begin
        // write the entry read last cycle one place toward the front
        wr_en   = rd_vld;
        wr_addr = slot_of(head, rd_idx - CNT_ONE);
        wr_data = rd_data;
        if (scan_k < count) begin
          rd_en = 1'b1;
        end
      end
      S_FRONT_RD: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      S_FRONT_WR: begin
        if (need_back) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(head, count - CNT_ONE);
        end
      end
      S_BACK_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_of(head, count - CNT_ONE);
      end
      default: begin
      end
    endcase
  end

  // Tag outstanding reads with their position from the front
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= scan_k;
    end
  end

  // Sequence each request through read, modify and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= CNT_ZERO;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      // Hold a result until taken; load the next one as its request completes
      if (state == S_RESULT) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            val       <= req.data_value;
            op        <= func_t'(req.func);
            op_found  <= 1'b0;
            op_status <= STAT_OK;
            scan_k    <= CNT_ZERO;
            need_back <= 1'b0;
            state     <= S_RESULT;
            case (func_t'(req.func))
              FUNC_PUSH_FRONT: begin
                if (count >= CNT_FULL) begin
                  op_status <= STAT_FULL;
                end else begin
                  head  <= prev_slot(head);
                  count <= count + CNT_ONE;
                  front <= req.data_value;
                  if (count == CNT_ZERO) begin
                    back <= req.data_value;
                  end
                end
              end
              FUNC_PUSH_BACK: begin
                if (count >= CNT_FULL) begin
                  op_status <= STAT_FULL;
                end else begin
                  count <= count + CNT_ONE;
                  back  <= req.data_value;
                  if (count == CNT_ZERO) begin
                    front <= req.data_value;
                  end
                end
              end
              FUNC_POP_FRONT: begin
                if (count == CNT_ZERO) begin
                  op_status <= STAT_EMPTY;
                end else begin
                  head  <= next_slot(head);
                  count <= count - CNT_ONE;
                  if (count != CNT_ONE) begin
                    state <= S_FRONT_RD;
                  end
                end
              end
              FUNC_POP_BACK: begin
                if (count == CNT_ZERO) begin
                  op_status <= STAT_EMPTY;
                end else begin
                  count <= count - CNT_ONE;
                  if (count != CNT_ONE) begin
                    state <= S_BACK_RD;
                  end
                end
              end
              FUNC_CONTAINS, FUNC_REMOVE: begin
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            op_found <= 1'b1;
            if (op == FUNC_REMOVE) begin
              scan_k <= rd_idx + CNT_ONE;
              state  <= S_SHIFT;
            end else begin
              state <= S_RESULT;
            end
          end else if (scan_k < count) begin
            scan_k <= scan_k + CNT_ONE;
          end else begin
            state <= S_RESULT;
          end
        end
        S_SHIFT: begin
          if (scan_k < count) begin
            scan_k <= scan_k + CNT_ONE;
          end else begin
            count <= count - CNT_ONE;
            if (count == CNT_ONE) begin
              state <= S_RESULT;
            end else begin
              need_back <= 1'b1;
              state     <= S_FRONT_RD;
            end
          end
        end
        S_FRONT_RD: begin
          state <= S_FRONT_WR;
        end
        S_FRONT_WR: begin
          front <= rd_data;
          state <= need_back ? S_BACK_WR : S_RESULT;
        end
        S_BACK_RD: begin
          state <= S_BACK_WR;
        end
        S_BACK_WR: begin
          back  <= rd_data;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Load the result register as the request completes
  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!rsp_valid || rsp.ready)) begin
      rsp.found       <= op_found;
      rsp.front_value <= (count == CNT_ZERO) ? '0 : front;
      rsp.back_value  <= (count == CNT_ZERO) ? '0 : back;
      rsp.entry_count <= COUNT_W'(count);
      rsp.is_empty    <= (count == CNT_ZERO);
      rsp.status      <= op_status;
    end
  end

endmodule

// ===== rtl/dwbs_checker.sv =====
// Port-level assertions for deque_with_bag_search, bound to the top level.
// Depends on dwbs_pkg for sizes and status codes.
module dwbs_port_checker import dwbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               found,
  input logic [DATA_W-1:0]  front_value,
  input logic [DATA_W-1:0]  back_value,
  input logic [COUNT_W-1:0] entry_count,
  input logic               is_empty,
  input logic [STAT_W-1:0]  status
);

  // Hold the count and status of a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(status))
    else $error("result changed while stalled");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // Empty queue reports zero ends
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> (front_value == '0) && (back_value == '0))
    else $error("nonzero front or back on empty queue");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= COUNT_W'(DEPTH)))
    else $error("entry_count above capacity");

  // An error result never reports a match
  a_err_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != STAT_OK) |-> !found)
    else $error("found set on an error result");

endmodule

bind deque_with_bag_search dwbs_port_checker u_dwbs_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .front_value (rsp.front_value),
  .back_value  (rsp.back_value),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .status      (rsp.status)
);

// ===== test/dwbs_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the deque with bag search. It watches the request and
// result channels, keeps a shadow copy of the ring and compares each result.
// Depends on dwbs_pkg and on the channel interfaces in dwbs_if.
module dwbs_checker import dwbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  dwbs_req_if  req,
  dwbs_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic               found;
    word_t              front_value;
    word_t              back_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    status_t            status;
  } deque_snapshot_t;

  word_t           shadow_ring [DEPTH];
  int unsigned     shadow_head;
  int unsigned     shadow_count;
  deque_snapshot_t awaited_snapshots [$];

  // Map a position counted from the front to its ring slot
  function automatic int unsigned ring_slot(int unsigned k);
    return (shadow_head + k) % DEPTH;
  endfunction

  // Apply one request to the shadow deque and return the state it must report
  function automatic deque_snapshot_t apply_deque_op(logic [FUNC_W-1:0] op, word_t value);
    deque_snapshot_t snap;
    int              hit;
    snap        = '0;
    snap.status = STAT_OK;
    hit         = -1;
    case (op)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          snap.status = STAT_FULL;
        end else if (op == FUNC_PUSH_FRONT) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = value;
          shadow_count++;
        end else begin
          shadow_ring[ring_slot(shadow_count)] = value;
          shadow_count++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (shadow_count == 0) begin
          snap.status = STAT_EMPTY;
        end else begin
          if (op == FUNC_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
          end
          shadow_count--;
        end
      end
      FUNC_CONTAINS, FUNC_REMOVE: begin
        // find the first match from the front
        for (int k = 0; k < int'(shadow_count); k++) begin
          if (hit < 0 && shadow_ring[ring_slot(k)] == value) begin
            hit = k;
          end
        end
        snap.found = (hit >= 0);
        // close the gap behind the removed entry
        if (hit >= 0 && op == FUNC_REMOVE) begin
          for (int j = hit; j + 1 < int'(shadow_count); j++) begin
            shadow_ring[ring_slot(j)] = shadow_ring[ring_slot(j + 1)];
          end
          shadow_count--;
        end
      end
      default: begin
        // spare codes leave the deque untouched
      end
    endcase
    if (shadow_count != 0) begin
      snap.front_value = shadow_ring[ring_slot(0)];
      snap.back_value  = shadow_ring[ring_slot(shadow_count - 1)];
    end
    snap.entry_count = COUNT_W'(shadow_count);
    snap.is_empty    = (shadow_count == 0);
    return snap;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result with the oldest open request, then log new requests
  always @(posedge clk) begin
    deque_snapshot_t want;
    if (rst) begin
      shadow_head  = 0;
      shadow_count = 0;
      awaited_snapshots.delete();
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_snapshots.size() == 0) begin
          $error("result arrived with no open request");
          fail_count++;
        end else begin
          want = awaited_snapshots.pop_front();
          check_field("found", want.found, rsp.found);
          check_field("front_value", $signed(want.front_value), rsp.front_value);
          check_field("back_value", $signed(want.back_value), rsp.back_value);
          check_field("entry_count", want.entry_count, rsp.entry_count);
          check_field("is_empty", want.is_empty, rsp.is_empty);
          check_field("status", want.status, rsp.status);
        end
      end
      if (req.valid && req.ready) begin
        awaited_snapshots.push_back(apply_deque_op(req.func, req.data_value));
      end
      pending = awaited_snapshots.size();
    end
  end

endmodule

// ===== test/deque_with_bag_search_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the deque with bag search: clock, reset, request traffic
// and result back-pressure. Checking lives in dwbs_checker.
// Depends on dwbs_pkg, dwbs_if, the block and dwbs_checker.
module deque_with_bag_search_test;
  import dwbs_pkg::*;

  // Spare func codes, treated by the block as no operation
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // Longest quiet stretch of a correct run is a full-depth remove plus a
  // stalled receiver; allow many times that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 580;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_SEARCH,
    MODE_MIX
  } traffic_mode_t;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  dwbs_req_if req_bus ();
  dwbs_rsp_if rsp_bus ();

  deque_with_bag_search i_dut (
    .clk,
    .rst,
    .req (req_bus),
    .rsp (rsp_bus)
  );

  dwbs_checker i_checker (
    .clk,
    .rst,
    .req (req_bus),
    .rsp (rsp_bus),
    .fail_count,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop result ready at random, and hold it low during reset
  always @(negedge clk) begin
    rsp_bus.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request, after an optional random gap, and hold until taken
  task automatic send_request(input logic [FUNC_W-1:0] op, input word_t value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.func       <= op;
    req_bus.data_value <= value;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Full random word, with the extremes mixed in often
  function automatic word_t random_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(traffic_mode_t mode);
    int roll;
    logic [FUNC_W-1:0] push_op;
    logic [FUNC_W-1:0] pop_op;
    logic [FUNC_W-1:0] search_op;
    roll      = $urandom_range(99);
    push_op   = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    pop_op    = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    search_op = $urandom_range(1) ? FUNC_CONTAINS : FUNC_REMOVE;
    case (mode)
      MODE_FILL:   return (roll < 85) ? push_op : (roll < 90) ? pop_op : search_op;
      MODE_DRAIN:  return (roll < 80) ? pop_op : (roll < 88) ? push_op : search_op;
      MODE_SEARCH: return (roll < 30) ? push_op : (roll < 42) ? pop_op : search_op;
      default:     return FUNC_W'($urandom_range(FUNC_REMOVE));
    endcase
  endfunction

  // Ends of the value range, every operation, spare codes and the empty-queue corners
  task automatic run_directed();
    send_request(FUNC_POP_FRONT, 32'h0);
    send_request(FUNC_POP_BACK, 32'h0);
    send_request(FUNC_CONTAINS, 32'h0);
    send_request(FUNC_REMOVE, 32'h0);
    send_request(FUNC_SPARE_LO, 32'h7FFF_FFFF);
    send_request(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(FUNC_PUSH_BACK, 32'h8000_0000);
    send_request(FUNC_PUSH_FRONT, 32'h0000_0000);
    send_request(FUNC_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(FUNC_PUSH_BACK, 32'h5A5A_5A5A);
    send_request(FUNC_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(FUNC_CONTAINS, 32'h8000_0000);
    send_request(FUNC_CONTAINS, 32'h1234_5678);
    send_request(FUNC_REMOVE, 32'h1234_5678);
    send_request(FUNC_REMOVE, 32'h7FFF_FFFF);
    send_request(FUNC_REMOVE, 32'hA5A5_A5A5);
    send_request(FUNC_REMOVE, 32'h5A5A_5A5A);
    send_request(FUNC_SPARE_HI, 32'h0);
    send_request(FUNC_POP_FRONT, 32'h0);
    send_request(FUNC_POP_BACK, 32'h0);
    send_request(FUNC_POP_FRONT, 32'h0);
    send_request(FUNC_POP_BACK, 32'h0);
  endtask

  // Episodes of fill, drain, search or mixed traffic over a small value pool,
  // so that duplicates, hits, full and empty all come up often
  task automatic run_random(input int item_total);
    int            sent;
    int            burst;
    traffic_mode_t mode;
    word_t         pool [8];
    word_t         value;
    sent = 0;
    while (sent < item_total) begin
      mode  = traffic_mode_t'($urandom_range(MODE_MIX));
      burst = $urandom_range(40, 120);
      // trim the last episode to the phase total
      if (burst > item_total - sent) begin
        burst = item_total - sent;
      end
      foreach (pool[i]) pool[i] = random_value();
      repeat (burst) begin
        value = ($urandom_range(3) == 0) ? random_value() : pool[$urandom_range(7)];
        send_request(pick_op(mode), value);
        sent++;
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    quiet_cycles       = 0;
    req_bus.valid      = 1'b0;
    req_bus.func       = '0;
    req_bus.data_value = '0;
    rsp_bus.ready      = 1'b0;
    send_idle_pct      = 7;
    recv_idle_pct      = 46;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 46;
    recv_idle_pct = 7;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);

    // Release the channel, drain open requests, then let the block settle
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dwbs_pkg.sv
rtl/dwbs_if.sv
rtl/dwbs_ram.sv
rtl/deque_with_bag_search.sv
rtl/dwbs_checker.sv
test/dwbs_checker.sv
test/deque_with_bag_search_test.sv
